>>> hw/rtl/dtsf_pkg.sv
// Package for the dual threshold sequence filter.
// Holds fixed widths, register indexes, the configuration struct and a saturating increment helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtsf_pkg;

   localparam int CNT_W      = 10;
   localparam int GAIN_W     = 13;
   localparam int THR_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_LENGTH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_HIGH       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BYPASS         = 3'd4;

   typedef struct packed {
      logic [THR_W-1:0] low_threshold;
      logic [THR_W-1:0] high_threshold;
      logic [CNT_W-1:0] min_length;
      logic [CNT_W-1:0] min_high;
      logic             bypass;
   } cfg_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dtsf_req_if.sv
// Request channel of the dual threshold sequence filter: valid, ready, sample payload.
// Depends on dtsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dtsf_req_if #(
   parameter int ADC_W = 8,
   parameter int TB_W  = 9
);
   import dtsf_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADC_W-1:0]  adc;
   logic [TB_W-1:0]   time_bin;
   logic [GAIN_W-1:0] gain_q;
   logic              seq_last;

   modport source (output valid, adc, time_bin, gain_q, seq_last, input ready);
   modport sink   (input valid, adc, time_bin, gain_q, seq_last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dtsf_rsp_if.sv
// Response channel of the dual threshold sequence filter: valid, ready, run payload.
// Depends on dtsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dtsf_rsp_if #(
   parameter int TB_W = 9
);
   import dtsf_pkg::*;

   logic             valid;
   logic             ready;
   logic [TB_W-1:0]  start_bin;
   logic [CNT_W-1:0] run_length;

   modport source (output valid, start_bin, run_length, input ready);
   modport sink   (input valid, start_bin, run_length, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dtsf_csr_if.sv
// Configuration write channel of the dual threshold sequence filter.
// Depends on dtsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dtsf_csr_if;
   import dtsf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dual_threshold_sequence_filter.sv
// Dual threshold sequence filter: zero suppression of gain-scaled ADC samples.
// Channels: req_chan takes one sample per request (adc, time_bin, gain_q,
// seq_last); rsp_chan returns kept runs as start_bin and run_length;
// csr_chan writes the five configuration registers, always ready.
// An accepted request is written into the queue and classified in the back
// end when popped; a response it causes is registered in the response register.
// Throughput is one request per cycle unless a held response stalls the back
// end, set by the single gain multiplier in front and the back-end run update.
// A two-entry queue decouples the two; when rsp_chan stalls, requests that
// yield no response still drain, and req_chan.ready drops once the queue
// fills behind a held response.
// Reset clears the registers, run and sequence state, the queue and the
// response valid flag. Write configuration only while the block is idle.
// Depends on dtsf_pkg, the three channel interfaces, dtsf_csr, dtsf_front,
// dtsf_queue and dtsf_back.
`timescale 1ns / 1ps
`default_nettype none

module dual_threshold_sequence_filter #(
   parameter int ADC_BITS       = 8,
   parameter int TIME_BINS      = 512,
   parameter int GAIN_FRAC_BITS = 8
) (
   input  wire        clock,
   input  wire        reset,
   dtsf_req_if.sink   req_chan,
   dtsf_rsp_if.source rsp_chan,
   dtsf_csr_if.sink   csr_chan
);
   import dtsf_pkg::*;

   localparam int TB_W   = $clog2(TIME_BINS);
   localparam int PROD_W = ADC_BITS + GAIN_W;
   localparam int ENT_W  = PROD_W + TB_W + 1;

   cfg_type           cfg;
   logic              queue_full, push, pop, head_valid, push_last;
   logic [PROD_W-1:0] push_prod;
   logic [TB_W-1:0]   push_tb;
   logic [ENT_W-1:0]  head_data;

   dtsf_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   dtsf_front #(
      .ADC_BITS  (ADC_BITS),
      .TIME_BINS (TIME_BINS),
      .TB_W      (TB_W),
      .PROD_W    (PROD_W)
   ) u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_prod  (push_prod),
      .push_tb    (push_tb),
      .push_last  (push_last)
   );

   dtsf_queue #(
      .WIDTH (ENT_W),
      .DEPTH (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({push_prod, push_tb, push_last}),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   dtsf_back #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .TB_W           (TB_W),
      .PROD_W         (PROD_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_prod  (head_data[ENT_W-1 -: PROD_W]),
      .head_tb    (head_data[TB_W:1]),
      .head_last  (head_data[0]),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

>>> hw/rtl/dtsf_csr.sv
// Configuration registers of the dual threshold sequence filter.
// Depends on dtsf_pkg and dtsf_csr_if.
`timescale 1ns / 1ps
`default_nettype none

module dtsf_csr (
   input  wire              clock,
   input  wire              reset,
   dtsf_csr_if.sink         csr_chan,
   output dtsf_pkg::cfg_type cfg
);
   import dtsf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_LOW_THRESHOLD:  cfg_in.low_threshold  = csr_chan.data[THR_W-1:0];
            REG_HIGH_THRESHOLD: cfg_in.high_threshold = csr_chan.data[THR_W-1:0];
            REG_MIN_LENGTH:     cfg_in.min_length     = csr_chan.data[CNT_W-1:0];
            REG_MIN_HIGH:       cfg_in.min_high       = csr_chan.data[CNT_W-1:0];
            REG_BYPASS:         cfg_in.bypass         = csr_chan.data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/dtsf_front.sv
// Front end: accepts requests, reduces the time bin and forms the gain product.
// Depends on dtsf_pkg and dtsf_req_if; feeds dtsf_queue.
`timescale 1ns / 1ps
`default_nettype none

module dtsf_front #(
   parameter int ADC_BITS  = 8,
   parameter int TIME_BINS = 512,
   parameter int TB_W      = 9,
   parameter int PROD_W    = 21
) (
   dtsf_req_if.sink               req_chan,
   input  wire                    queue_full,
   output logic                   push,
   output logic [PROD_W-1:0]      push_prod,
   output logic [TB_W-1:0]        push_tb,
   output logic                   push_last
);
   import dtsf_pkg::*;

   localparam logic [TB_W:0] BINS = (TB_W + 1)'(TIME_BINS);

   logic [TB_W:0] tb_ext;

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   assign tb_ext    = {1'b0, req_chan.time_bin};
   assign push_tb   = (tb_ext >= BINS) ? TB_W'(tb_ext - BINS) : req_chan.time_bin;
   assign push_prod = PROD_W'(req_chan.adc[ADC_BITS-1:0]) * PROD_W'(req_chan.gain_q);
   assign push_last = req_chan.seq_last;

endmodule

`default_nettype wire

>>> hw/rtl/dtsf_queue.sv
// Two-entry request queue between front end and back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dtsf_queue #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 2
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  wire  [WIDTH-1:0]  push_data,
   output logic              full,
   input  wire               pop,
   output logic              head_valid,
   output logic [WIDTH-1:0]  head_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/dtsf_back.sv
// Back end: threshold tests, run and sequence tracking, response register.
// Depends on dtsf_pkg and dtsf_rsp_if; fed by dtsf_queue.
`timescale 1ns / 1ps
`default_nettype none

module dtsf_back #(
   parameter int GAIN_FRAC_BITS = 8,
   parameter int TB_W           = 9,
   parameter int PROD_W         = 21
) (
   input  wire                    clock,
   input  wire                    reset,
   input  dtsf_pkg::cfg_type      cfg,
   input  wire                    head_valid,
   input  wire  [PROD_W-1:0]      head_prod,
   input  wire  [TB_W-1:0]        head_tb,
   input  wire                    head_last,
   output logic                   pop,
   dtsf_rsp_if.source             rsp_chan
);
   import dtsf_pkg::*;

   localparam int CMP_W = (PROD_W > THR_W + GAIN_FRAC_BITS) ? PROD_W
                                                            : THR_W + GAIN_FRAC_BITS;

   logic             in_run_ff, in_run_in;
   logic [TB_W-1:0]  run_start_ff, run_start_in;
   logic [CNT_W-1:0] run_count_ff, run_count_in;
   logic [CNT_W-1:0] high_count_ff, high_count_in;
   logic [TB_W-1:0]  seq_start_ff, seq_start_in;
   logic [CNT_W-1:0] seq_count_ff, seq_count_in;

   logic             rsp_valid_ff;
   logic [TB_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [CNT_W-1:0] rsp_len_ff, rsp_len_in;

   logic [CMP_W-1:0] prod_ext;
   logic             above, high, closed, emit;
   logic [CNT_W-1:0] seq_len;

   assign prod_ext = CMP_W'(head_prod);
   // scaled value saturates at the threshold maximum
   assign above    = (cfg.low_threshold != '1)
                     && ((prod_ext >> GAIN_FRAC_BITS) > CMP_W'(cfg.low_threshold));
   assign high     = prod_ext > (CMP_W'(cfg.high_threshold) << GAIN_FRAC_BITS);

   always_comb begin
      in_run_in     = in_run_ff;
      run_start_in  = run_start_ff;
      run_count_in  = run_count_ff;
      high_count_in = high_count_ff;
      closed        = 1'b0;

      seq_start_in = (seq_count_ff == '0) ? head_tb : seq_start_ff;
      seq_len      = sat_inc(seq_count_ff);
      seq_count_in = head_last ? '0 : seq_len;

      if (above) begin
         if (!in_run_ff) begin
            run_start_in  = head_tb;
            run_count_in  = '0;
            high_count_in = '0;
         end
         run_count_in = sat_inc(run_count_in);
         if (high) begin
            high_count_in = sat_inc(high_count_in);
         end
         in_run_in = !head_last;
         closed    = head_last;
      end else if (in_run_ff) begin
         in_run_in = 1'b0;
         closed    = 1'b1;
      end

      if (cfg.bypass) begin
         emit         = head_last;
         rsp_start_in = seq_start_in;
         rsp_len_in   = seq_len;
      end else begin
         emit         = closed && (run_count_in > cfg.min_length)
                               && (high_count_in > cfg.min_high);
         rsp_start_in = run_start_in;
         rsp_len_in   = run_count_in;
      end
   end

   assign pop = head_valid && (!emit || !rsp_valid_ff || rsp_chan.ready);

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.start_bin  = rsp_start_ff;
   assign rsp_chan.run_length = rsp_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff     <= 1'b0;
         run_start_ff  <= '0;
         run_count_ff  <= '0;
         high_count_ff <= '0;
         seq_start_ff  <= '0;
         seq_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (pop) begin
            in_run_ff     <= in_run_in;
            run_start_ff  <= run_start_in;
            run_count_ff  <= run_count_in;
            high_count_ff <= high_count_in;
            seq_start_ff  <= seq_start_in;
            seq_count_ff  <= seq_count_in;
         end
         if (pop && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_start_ff <= rsp_start_in;
         rsp_len_ff   <= rsp_len_in;
      end
   end

endmodule

`default_nettype wire

>>> tb/sv/tb_dual_threshold_sequence_filter.sv
// Self-checking testbench for dual_threshold_sequence_filter: directed table, saturation
// runs and random sample sequences, scored by an in-bench run/sequence tracker or table.
// Depends on dtsf_pkg, the three channel interfaces and the filter RTL.
`timescale 1ns / 1ps

module tb_dual_threshold_sequence_filter;
   import dtsf_pkg::*;

   localparam int ADC_BITS       = 8;
   localparam int TIME_BINS      = 512;
   localparam int GAIN_FRAC_BITS = 8;
   localparam int TB_W           = 9;

   localparam int RESET_CYCLES  = 5;
   localparam int DRAIN_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 64;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 12;
   localparam int LONG_SEQ      = 1025;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [ADC_BITS-1:0] adc;
      logic [TB_W-1:0]     time_bin;
      logic [GAIN_W-1:0]   gain_q;
      logic                seq_last;
   } sample_type;

   typedef struct packed {
      logic [TB_W-1:0]  start_bin;
      logic [CNT_W-1:0] run_length;
   } run_type;

   typedef struct packed {
      logic             in_run;
      logic [TB_W-1:0]  run_start;
      logic [CNT_W-1:0] run_count;
      logic [CNT_W-1:0] high_count;
      logic [TB_W-1:0]  seq_start;
      logic [CNT_W-1:0] seq_count;
   } tracker_type;

   typedef struct packed {
      logic                  is_write;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      sample_type            smp;
      logic                  typed;
      logic                  exp_hit;
      run_type               exp_run;
   } step_type;

   logic clock = 1'b0;
   logic reset;

   dtsf_req_if #(.ADC_W(ADC_BITS), .TB_W(TB_W)) req_chan ();
   dtsf_rsp_if #(.TB_W(TB_W))                   rsp_chan ();
   dtsf_csr_if                                  csr_chan ();

   dual_threshold_sequence_filter #(
      .ADC_BITS       (ADC_BITS),
      .TIME_BINS      (TIME_BINS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   cfg_type     shadow_cfg = '0;
   tracker_type trk        = '0;
   run_type     pending_runs[$];
   step_type    directed[$];

   int mismatches  = 0;
   int idle_cycles = 0;
   int phase_items = 0;
   bit sender_gaps = 1'b0;
   bit rsp_gaps    = 1'b0;
   bit calm        = 1'b0;
   bit hold_rsp    = 1'b0;

   function automatic logic [CNT_W-1:0] bump10(input logic [CNT_W-1:0] v);
      return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   function automatic void apply_write(input logic [CSR_IDX_W-1:0] idx,
                                       input logic [CSR_DATA_W-1:0] val);
      case (idx)
         REG_LOW_THRESHOLD:  shadow_cfg.low_threshold  = val;
         REG_HIGH_THRESHOLD: shadow_cfg.high_threshold = val;
         REG_MIN_LENGTH:     shadow_cfg.min_length     = val[CNT_W-1:0];
         REG_MIN_HIGH:       shadow_cfg.min_high       = val[CNT_W-1:0];
         REG_BYPASS:         shadow_cfg.bypass         = val[0];
         default: ;
      endcase
   endfunction

   // Tracks runs and sequences for one accepted request; returns 1 when a run is emitted.
   function automatic bit filter_sample(input sample_type s, output run_type r);
      logic [31:0]      prod;
      logic [31:0]      scaled;
      logic [CNT_W-1:0] c_high;
      bit               above;
      bit               high;
      bit               closed;
      bit               hit;
      run_type          c;
      run_type          sq;
      prod   = 32'(s.adc) * 32'(s.gain_q);
      scaled = prod >> GAIN_FRAC_BITS;
      if (scaled > 32'hFFFF) scaled = 32'hFFFF;
      above  = scaled > 32'(shadow_cfg.low_threshold);
      high   = prod > (32'(shadow_cfg.high_threshold) << GAIN_FRAC_BITS);
      closed = 1'b0;
      c      = '0;
      c_high = '0;
      if (trk.seq_count == 0) trk.seq_start = s.time_bin;
      trk.seq_count = bump10(trk.seq_count);
      if (above) begin
         if (!trk.in_run) begin
            trk.in_run     = 1'b1;
            trk.run_start  = s.time_bin;
            trk.run_count  = '0;
            trk.high_count = '0;
         end
         trk.run_count = bump10(trk.run_count);
         if (high) trk.high_count = bump10(trk.high_count);
         if (s.seq_last) begin
            closed = 1'b1;
            c      = '{trk.run_start, trk.run_count};
            c_high = trk.high_count;
            trk.in_run = 1'b0;
         end
      end else if (trk.in_run) begin
         closed = 1'b1;
         c      = '{trk.run_start, trk.run_count};
         c_high = trk.high_count;
         trk.in_run = 1'b0;
      end
      sq = '{trk.seq_start, trk.seq_count};
      if (s.seq_last) trk.seq_count = '0;
      if (shadow_cfg.bypass) begin
         r   = sq;
         hit = s.seq_last;
      end else begin
         r   = c;
         hit = closed && (c.run_length > shadow_cfg.min_length)
                      && (c_high > shadow_cfg.min_high);
      end
      return hit;
   endfunction

   function automatic step_type wr(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] val);
      step_type st;
      st          = '0;
      st.is_write = 1'b1;
      st.reg_idx  = idx;
      st.reg_val  = val;
      return st;
   endfunction

   function automatic step_type probe(input int adc, input int bin, input int gain,
                                      input bit last);
      step_type st;
      st     = '0;
      st.smp = '{8'(adc), 9'(bin), 13'(gain), last};
      return st;
   endfunction

   function automatic step_type known(input int adc, input int bin, input int gain,
                                      input bit last, input bit hit, input int start,
                                      input int len);
      step_type st;
      st         = probe(adc, bin, gain, last);
      st.typed   = 1'b1;
      st.exp_hit = hit;
      st.exp_run = '{9'(start), 10'(len)};
      return st;
   endfunction

   task automatic offer_sample(input sample_type s, input bit typed, input bit exp_hit,
                               input run_type exp_run);
      run_type r;
      bit      hit;
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.adc      <= s.adc;
      req_chan.time_bin <= s.time_bin;
      req_chan.gain_q   <= s.gain_q;
      req_chan.seq_last <= s.seq_last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      hit = filter_sample(s, r);
      if (typed) begin
         hit = exp_hit;
         r   = exp_run;
      end
      if (hit) pending_runs.push_back(r);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      apply_write(idx, val);
   endtask

   task automatic program_cfg(input int low, input int high, input int min_len,
                              input int min_hi, input bit byp);
      csr_write(REG_LOW_THRESHOLD, 16'(low));
      csr_write(REG_HIGH_THRESHOLD, 16'(high));
      csr_write(REG_MIN_LENGTH, 16'(min_len));
      csr_write(REG_MIN_HIGH, 16'(min_hi));
      csr_write(REG_BYPASS, 16'(byp));
      csr_chan.valid <= 1'b0;
   endtask

   task automatic await_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_runs.size() != 0);
   endtask

   task automatic settle();
      await_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic emit_sequence(input int len, input bit hot);
      logic [TB_W-1:0]   first_bin;
      logic [GAIN_W-1:0] pad_gain;
      sample_type        s;
      run_type           none;
      none      = '0;
      first_bin = 9'($urandom_range(0, 511));
      if (hot) pad_gain = 13'($urandom_range(256, 8191));
      else if ($urandom_range(0, 3) == 0) pad_gain = 13'($urandom_range(0, 8191));
      else pad_gain = 13'($urandom_range(64, 600));
      for (int k = 0; k < len; k++) begin
         if (!hot && $urandom_range(0, 11) == 0) begin
            s = sample_type'(31'($urandom()));
            offer_sample(s, 1'b0, 1'b0, none);
            phase_items++;
         end
         if (hot) s.adc = 8'($urandom_range(1, 255));
         else if ($urandom_range(0, 3) == 0) s.adc = 8'($urandom_range(0, 15));
         else s.adc = 8'($urandom_range(0, 255));
         s.time_bin = first_bin + 9'(k);
         s.gain_q   = pad_gain;
         s.seq_last = (k == len - 1);
         offer_sample(s, 1'b0, 1'b0, none);
         phase_items++;
      end
   endtask

   // one long sequence: the run saturates and closes on a quiet sample,
   // then bypass is set and the saturated sequence ends
   task automatic saturate_counters();
      logic [TB_W-1:0] first_bin;
      sample_type      s;
      run_type         none;
      none       = '0;
      first_bin  = 9'($urandom_range(0, 511));
      s.gain_q   = 13'($urandom_range(256, 8191));
      s.seq_last = 1'b0;
      for (int k = 0; k < LONG_SEQ; k++) begin
         s.adc      = 8'($urandom_range(1, 255));
         s.time_bin = first_bin + 9'(k);
         offer_sample(s, 1'b0, 1'b0, none);
      end
      s.adc      = '0;
      s.time_bin = first_bin + 9'(LONG_SEQ);
      offer_sample(s, 1'b0, 1'b0, none);
      settle();
      csr_write(REG_BYPASS, 16'd1);
      csr_chan.valid <= 1'b0;
      s.time_bin = first_bin + 9'(LONG_SEQ + 1);
      s.seq_last = 1'b1;
      offer_sample(s, 1'b0, 1'b0, none);
   endtask

   // response side: random back-pressure, plus one long hold-off on request
   initial begin
      rsp_chan.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_chan.ready <= 1'b1;
            hold_rsp = 1'b0;
         end else if (rsp_gaps && !calm && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      run_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_runs.size() == 0) begin
            $display("%0t unexpected run: expected none, actual start_bin %0d run_length %0d",
                     $time, rsp_chan.start_bin, rsp_chan.run_length);
            mismatches++;
         end else begin
            want = pending_runs.pop_front();
            if (rsp_chan.start_bin !== want.start_bin) begin
               $display("%0t start_bin mismatch: expected %0d, actual %0d",
                        $time, want.start_bin, rsp_chan.start_bin);
               mismatches++;
            end
            if (rsp_chan.run_length !== want.run_length) begin
               $display("%0t run_length mismatch: expected %0d, actual %0d",
                        $time, want.run_length, rsp_chan.run_length);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t no progress for %0d cycles, %0d runs outstanding",
                  $time, STALL_LIMIT, pending_runs.size());
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      bit in_writes;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.adc      <= '0;
      req_chan.time_bin <= '0;
      req_chan.gain_q   <= '0;
      req_chan.seq_last <= 1'b0;
      csr_chan.valid    <= 1'b0;
      csr_chan.index    <= '0;
      csr_chan.data     <= '0;

      // reset defaults: any nonzero scaled value opens a run, every run is kept
      directed.push_back(known(0, 0, 0, 0, 0, 0, 0));
      directed.push_back(known(255, 511, 8191, 0, 0, 0, 0));
      directed.push_back(known(0, 0, 8191, 0, 1, 511, 1));
      directed.push_back(known(1, 5, 1, 0, 0, 0, 0));
      directed.push_back(known(1, 6, 256, 1, 1, 6, 1));
      directed.push_back(known(255, 100, 0, 1, 0, 0, 0));
      // whole sequences pass through
      directed.push_back(wr(REG_BYPASS, 16'd1));
      directed.push_back(known(0, 200, 0, 0, 0, 0, 0));
      directed.push_back(probe(255, 300, 8191, 0));
      directed.push_back(known(7, 9, 4000, 1, 1, 200, 3));
      directed.push_back(known(0, 511, 0, 1, 1, 511, 1));
      // bypass dropped mid-sequence: the run closing afterwards is emitted
      directed.push_back(probe(200, 20, 256, 0));
      directed.push_back(wr(REG_BYPASS, 16'd0));
      directed.push_back(known(0, 21, 0, 1, 1, 20, 1));
      // threshold edges, high test on the exact product
      directed.push_back(wr(REG_LOW_THRESHOLD, 16'd100));
      directed.push_back(wr(REG_HIGH_THRESHOLD, 16'd200));
      directed.push_back(wr(REG_MIN_LENGTH, 16'd1));
      directed.push_back(probe(101, 30, 256, 0));
      directed.push_back(probe(255, 31, 256, 0));
      directed.push_back(known(100, 32, 256, 0, 1, 30, 2));
      directed.push_back(probe(200, 40, 257, 0));
      directed.push_back(probe(200, 41, 256, 1));
      directed.push_back(wr(REG_MIN_HIGH, 16'd1));
      directed.push_back(probe(200, 50, 257, 0));
      directed.push_back(probe(200, 51, 256, 1));
      // register maxima, then writes to unmapped indexes must be ignored
      directed.push_back(wr(REG_LOW_THRESHOLD, 16'hFFFF));
      directed.push_back(wr(REG_HIGH_THRESHOLD, 16'hFFFF));
      directed.push_back(wr(REG_MIN_LENGTH, 16'd1023));
      directed.push_back(wr(REG_MIN_HIGH, 16'd1023));
      directed.push_back(wr(REG_SPARE_HI, 16'hFFFF));
      directed.push_back(wr(REG_SPARE_LO, 16'hFFFF));
      directed.push_back(known(255, 511, 8191, 1, 0, 0, 0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      in_writes = 1'b0;
      foreach (directed[i]) begin
         if (directed[i].is_write) begin
            if (!in_writes) settle();
            in_writes = 1'b1;
            csr_write(directed[i].reg_idx, directed[i].reg_val);
         end else begin
            if (in_writes) csr_chan.valid <= 1'b0;
            in_writes = 1'b0;
            offer_sample(directed[i].smp, directed[i].typed, directed[i].exp_hit,
                         directed[i].exp_run);
         end
      end

      // counters saturate on a very long run and sequence
      sender_gaps = 1'b1;
      rsp_gaps    = 1'b1;
      settle();
      program_cfg(0, 0, 1022, 1022, 1'b0);
      saturate_counters();

      for (int p = 0; p < PHASES; p++) begin
         bit pressed;
         settle();
         calm        = (p == PHASES - 1);
         sender_gaps = !calm && (p % 3 != 2) && (p != 0);
         rsp_gaps    = !calm && (p % 3 != 1);
         program_cfg(($urandom_range(0, 7) == 0) ? 16'hFFFF : $urandom_range(0, 200),
                     ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 800),
                     $urandom_range(0, 3), $urandom_range(0, 2),
                     (p == 0) || ($urandom_range(0, 3) == 0));
         phase_items = 0;
         pressed     = 1'b0;
         while (phase_items < PHASE_ITEMS) begin
            if (!pressed && phase_items >= 4 && p == 0) begin
               hold_rsp = 1'b1;
               pressed  = 1'b1;
            end
            emit_sequence((p == 0) ? $urandom_range(1, 3) : $urandom_range(1, 40), 1'b0);
            if (!pressed && p == 1) begin
               await_results();
               pressed = 1'b1;
            end
         end
      end

      settle();
      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
